[hw/rtl/bouncing_particle_integrator_assert.svh]
// Assertion macros shared by the particle integrator RTL.
`ifndef BOUNCING_PARTICLE_INTEGRATOR_ASSERT_SVH
`define BOUNCING_PARTICLE_INTEGRATOR_ASSERT_SVH

// Check a consequence in the same cycle as its cause.
`define BPI_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the cycle after its cause.
`define BPI_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hw/rtl/bpi_pkg.sv]
// Shared constants, codes and helpers of the particle integrator.
`default_nettype none

package bpi_pkg;

	// Item codes on the input side
	localparam logic [1:0] OP_PRESS   = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_TICK    = 2'd2;

	// Result kinds
	localparam logic KIND_ACK = 1'b0;
	localparam logic KIND_POS = 1'b1;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 23;
	localparam logic [CFG_IDX_W-1:0] CFG_TIME_STEP   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DRAG_RATIO  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESTITUTION = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LAUNCH_GAIN = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAVITY     = 3'd4;

	// Register widths and reset values
	localparam int TS_W   = 17;
	localparam int DRAG_W = 21;
	localparam int REST_W = 17;
	localparam int GAIN_W = 21;
	localparam int GRAV_W = 23;
	localparam logic [TS_W-1:0]   TS_RST   = 17'd655;
	localparam logic [DRAG_W-1:0] DRAG_RST = 21'd13107;
	localparam logic [REST_W-1:0] REST_RST = 17'd52429;
	localparam logic [GAIN_W-1:0] GAIN_RST = 21'd131072;
	localparam logic [GRAV_W-1:0] GRAV_RST = 23'd642253;

	// Datapath widths
	localparam int VAL_W      = 32;
	localparam int OPB_W      = 24;
	localparam int PROD_W     = VAL_W + OPB_W;
	localparam int SUM_W      = VAL_W + 2;
	localparam int ROW_W      = 4 * VAL_W;
	localparam int BALL_IDX_W = 6;

	// Clamp an exact sum to the signed 32-bit range
	function automatic logic signed [VAL_W-1:0] sat34(input logic signed [SUM_W-1:0] v);
		logic signed [VAL_W-1:0] r;
		if (v[SUM_W-1:VAL_W-1] == '0 || v[SUM_W-1:VAL_W-1] == '1) begin
			r = v[VAL_W-1:0];
		end else if (v[SUM_W-1]) begin
			r = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(VAL_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/bpi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bpi_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

[hw/rtl/bpi_mul.sv]
// Shared two-stage fixed-point multiplier with floor rounding and clamp.
`default_nettype none

module bpi_mul #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                               clk,
	input  wire logic signed [bpi_pkg::VAL_W-1:0]   a,
	input  wire logic signed [bpi_pkg::OPB_W-1:0]   b,
	output logic      signed [bpi_pkg::VAL_W-1:0]   p
);

	localparam int VW = bpi_pkg::VAL_W;
	localparam int PW = bpi_pkg::PROD_W;

	logic signed [PW-1:0] prod_s1;
	logic signed [PW-1:0] shr_c;

	// Stage one: exact product
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(a) * PW'(b);
	end

	// Arithmetic shift rounds toward minus infinity
	assign shr_c = prod_s1 >>> FRAC_BITS;

	// Stage two: clamp to the signed 32-bit range
	always_ff @(posedge clk) begin
		if (shr_c[PW-1:VW-1] == '0 || shr_c[PW-1:VW-1] == '1) begin
			p <= shr_c[VW-1:0];
		end else if (shr_c[PW-1]) begin
			p <= {1'b1, {(VW-1){1'b0}}};
		end else begin
			p <= {1'b0, {(VW-1){1'b1}}};
		end
	end

endmodule

`default_nettype wire

[hw/rtl/bouncing_particle_integrator.sv]
// Path to the output register: release, or press on a full table, goes straight to emit;
// other press: launch products, write, emit; tick per ball: read, load, then emit if paused,
// else 7 motion products (8 on a bounce), write, emit; all share the one multiplier.
// One word in at a time; input is taken again once the last word sits in the output register.
// Reset: no balls, motion paused, registers at defaults; the ball RAM is not cleared.
`default_nettype none

`include "bouncing_particle_integrator_assert.svh"

module bouncing_particle_integrator #(
	parameter int MAX_BALLS = 64,
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// configuration write port
	input  wire logic                                cfg_we,
	input  wire logic [bpi_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire logic [bpi_pkg::CFG_DATA_W-1:0]      cfg_data,
	// input words
	input  wire logic                                s_axis_tvalid,
	output logic                                     s_axis_tready,
	input  wire logic [63:0]                         s_axis_tdata,  // launch_x, launch_y
	input  wire logic [1:0]                          s_axis_tuser,  // op
	// result words
	output logic                                     m_axis_tvalid,
	input  wire logic                                m_axis_tready,
	output logic [71:0]                              m_axis_tdata,  // ball_index, pos_horizontal,
	                                                                // pos_vertical, zero pad
	output logic [1:0]                               m_axis_tuser,  // kind, table_full
	output logic                                     m_axis_tlast
);

	localparam int IW  = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;
	localparam int CW  = $clog2(MAX_BALLS + 1);
	localparam int VW  = bpi_pkg::VAL_W;
	localparam int SW  = bpi_pkg::SUM_W;
	localparam int BW  = bpi_pkg::OPB_W;
	localparam int XW  = bpi_pkg::BALL_IDX_W;
	localparam int RW  = bpi_pkg::ROW_W;

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_LOAD = 3'd2;
	localparam logic [2:0] ST_MUL  = 3'd3;
	localparam logic [2:0] ST_WR   = 3'd4;
	localparam logic [2:0] ST_EMIT = 3'd5;

	// Multiplier phases
	localparam logic [1:0] PH_ISSUE = 2'd0;
	localparam logic [1:0] PH_WAIT  = 2'd1;
	localparam logic [1:0] PH_USE   = 2'd2;

	// Arithmetic steps
	localparam logic [3:0] STP_LX = 4'd0;  // launch_x * gain
	localparam logic [3:0] STP_LY = 4'd1;  // launch_y * gain
	localparam logic [3:0] STP_GX = 4'd2;  // vx * dt
	localparam logic [3:0] STP_DX = 4'd3;  // drag * vx
	localparam logic [3:0] STP_TX = 4'd4;  // (drag * vx) * dt
	localparam logic [3:0] STP_GY = 4'd5;  // vy * dt
	localparam logic [3:0] STP_DY = 4'd6;  // drag * vy
	localparam logic [3:0] STP_TY = 4'd7;  // (drag * vy) * dt
	localparam logic [3:0] STP_GR = 4'd8;  // gravity * dt
	localparam logic [3:0] STP_RS = 4'd9;  // restitution * vy

	// Control state
	logic [2:0]    state_q;
	logic [1:0]    ph_q;
	logic [3:0]    step_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] idx_q;
	logic          running_q;
	logic          tick_q;
	logic          full_q;
	logic          out_valid_q;

	// Configuration registers
	logic [bpi_pkg::TS_W-1:0]   time_step_q;
	logic [bpi_pkg::DRAG_W-1:0] drag_ratio_q;
	logic [bpi_pkg::REST_W-1:0] restitution_q;
	logic [bpi_pkg::GAIN_W-1:0] launch_gain_q;
	logic [bpi_pkg::GRAV_W-1:0] gravity_q;

	// Working values of the current ball
	logic signed [VW-1:0] x_q;
	logic signed [VW-1:0] vx_q;
	logic signed [VW-1:0] y_q;
	logic signed [VW-1:0] vy_q;
	logic signed [VW-1:0] t_q;
	logic signed [SW-1:0] acc_q;

	// Output register payload
	logic          out_kind_q;
	logic          out_full_q;
	logic          out_last_q;
	logic [XW-1:0] out_idx_q;
	logic [VW-1:0] out_x_q;
	logic [VW-1:0] out_y_q;

	logic                 in_acc_c;
	logic [1:0]           op_c;
	logic                 out_free_c;
	logic                 out_load_c;
	logic                 table_full_c;
	logic [CW-1:0]        idx_next_c;
	logic                 last_ball_c;
	logic                 y_ground_c;
	logic signed [VW-1:0] mul_a_c;
	logic signed [BW-1:0] mul_b_c;
	logic signed [VW-1:0] mul_p;
	logic signed [VW-1:0] add_x_c;
	logic signed [VW-1:0] sub_vx_c;
	logic signed [VW-1:0] add_y_c;
	logic signed [SW-1:0] acc_c;
	logic signed [VW-1:0] vy_grav_c;
	logic signed [VW-1:0] vy_bounce_c;
	logic                 ram_we_c;
	logic [RW-1:0]        ram_wdata_c;
	logic [RW-1:0]        ram_rdata;

	// Handshakes
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_acc_c      = s_axis_tvalid && s_axis_tready;
	assign op_c          = s_axis_tuser;
	assign out_free_c    = !out_valid_q || m_axis_tready;
	assign out_load_c    = (state_q == ST_EMIT) && out_free_c;
	assign table_full_c  = (count_q == CW'(MAX_BALLS));
	assign idx_next_c    = CW'(idx_q) + CW'(1);
	assign last_ball_c   = (idx_next_c == count_q);
	assign y_ground_c    = y_q[VW-1] || (y_q == '0);

	// Select multiplier operands by step
	always_comb begin
		mul_a_c = vx_q;
		mul_b_c = BW'(time_step_q);
		case (step_q)
			STP_LX: begin
				mul_a_c = vx_q;
				mul_b_c = BW'(launch_gain_q);
			end
			STP_LY: begin
				mul_a_c = vy_q;
				mul_b_c = BW'(launch_gain_q);
			end
			STP_GX: begin
				mul_a_c = vx_q;
				mul_b_c = BW'(time_step_q);
			end
			STP_DX: begin
				mul_a_c = vx_q;
				mul_b_c = BW'(drag_ratio_q);
			end
			STP_TX, STP_TY: begin
				mul_a_c = t_q;
				mul_b_c = BW'(time_step_q);
			end
			STP_GY: begin
				mul_a_c = vy_q;
				mul_b_c = BW'(time_step_q);
			end
			STP_DY: begin
				mul_a_c = vy_q;
				mul_b_c = BW'(drag_ratio_q);
			end
			STP_GR: begin
				mul_a_c = VW'(gravity_q);
				mul_b_c = BW'(time_step_q);
			end
			STP_RS: begin
				mul_a_c = vy_q;
				mul_b_c = BW'(restitution_q);
			end
			default: begin
				mul_a_c = vx_q;
				mul_b_c = BW'(time_step_q);
			end
		endcase
	end

	bpi_mul #(
		.FRAC_BITS(FRAC_BITS)
	) u_mul (
		.clk(clk),
		.a  (mul_a_c),
		.b  (mul_b_c),
		.p  (mul_p)
	);

	// Exact sums, clamped; acc_c keeps its exact sum unclamped
	assign add_x_c     = bpi_pkg::sat34(SW'(x_q) + SW'(mul_p));
	assign sub_vx_c    = bpi_pkg::sat34(SW'(vx_q) - SW'(mul_p));
	assign add_y_c     = bpi_pkg::sat34(SW'(y_q) + SW'(mul_p));
	assign acc_c       = SW'(vy_q) - SW'(mul_p);
	assign vy_grav_c   = bpi_pkg::sat34(acc_q - SW'(mul_p));
	assign vy_bounce_c = bpi_pkg::sat34(SW'(0) - SW'(mul_p));

	// Ball table: one row of x, vx, y, vy per ball
	assign ram_we_c    = (state_q == ST_WR);
	assign ram_wdata_c = {vy_q, y_q, vx_q, x_q};

	bpi_ram #(
		.WIDTH(RW),
		.DEPTH(MAX_BALLS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we_c),
		.waddr(idx_q),
		.wdata(ram_wdata_c),
		.raddr(idx_q),
		.rdata(ram_rdata)
	);

	// Sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			ph_q          <= PH_ISSUE;
			step_q        <= STP_LX;
			count_q       <= '0;
			idx_q         <= '0;
			running_q     <= 1'b0;
			tick_q        <= 1'b0;
			full_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			time_step_q   <= bpi_pkg::TS_RST;
			drag_ratio_q  <= bpi_pkg::DRAG_RST;
			restitution_q <= bpi_pkg::REST_RST;
			launch_gain_q <= bpi_pkg::GAIN_RST;
			gravity_q     <= bpi_pkg::GRAV_RST;
		end else begin
			// take register writes
			if (cfg_we) begin
				case (cfg_index)
					bpi_pkg::CFG_TIME_STEP:   time_step_q   <= cfg_data[bpi_pkg::TS_W-1:0];
					bpi_pkg::CFG_DRAG_RATIO:  drag_ratio_q  <= cfg_data[bpi_pkg::DRAG_W-1:0];
					bpi_pkg::CFG_RESTITUTION: restitution_q <= cfg_data[bpi_pkg::REST_W-1:0];
					bpi_pkg::CFG_LAUNCH_GAIN: launch_gain_q <= cfg_data[bpi_pkg::GAIN_W-1:0];
					bpi_pkg::CFG_GRAVITY:     gravity_q     <= cfg_data[bpi_pkg::GRAV_W-1:0];
					default: ;
				endcase
			end

			// hold or drop the output word
			if (out_load_c) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (in_acc_c) begin
						tick_q <= 1'b0;
						full_q <= 1'b0;
						idx_q  <= '0;
						case (op_c)
							bpi_pkg::OP_PRESS: begin
								running_q <= 1'b0;
								if (table_full_c) begin
									full_q  <= 1'b1;
									state_q <= ST_EMIT;
								end else begin
									idx_q   <= count_q[IW-1:0];
									step_q  <= STP_LX;
									ph_q    <= PH_ISSUE;
									state_q <= ST_MUL;
								end
							end
							bpi_pkg::OP_RELEASE: begin
								running_q <= 1'b1;
								state_q   <= ST_EMIT;
							end
							bpi_pkg::OP_TICK: begin
								tick_q <= 1'b1;
								if (count_q != '0) begin
									state_q <= ST_RD;
								end
							end
							default: ;
						endcase
					end
				end
				ST_RD: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (running_q) begin
						step_q  <= STP_GX;
						ph_q    <= PH_ISSUE;
						state_q <= ST_MUL;
					end else begin
						state_q <= ST_EMIT;
					end
				end
				ST_MUL: begin
					if (ph_q != PH_USE) begin
						ph_q <= ph_q + 2'd1;
					end else begin
						ph_q <= PH_ISSUE;
						// advance to the next step
						case (step_q)
							STP_LX: step_q <= STP_LY;
							STP_LY: state_q <= ST_WR;
							STP_GX: step_q <= STP_DX;
							STP_DX: step_q <= STP_TX;
							STP_TX: step_q <= STP_GY;
							STP_GY: step_q <= STP_DY;
							STP_DY: step_q <= STP_TY;
							STP_TY: step_q <= STP_GR;
							STP_GR: begin
								if (y_ground_c) begin
									step_q <= STP_RS;
								end else begin
									state_q <= ST_WR;
								end
							end
							STP_RS: state_q <= ST_WR;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_WR: begin
					if (!tick_q) begin
						count_q <= count_q + CW'(1);
					end
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free_c) begin
						if (tick_q && !last_ball_c) begin
							idx_q   <= idx_next_c[IW-1:0];
							state_q <= ST_RD;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working values and output payload
	always_ff @(posedge clk) begin
		if (in_acc_c) begin
			x_q  <= '0;
			y_q  <= '0;
			vx_q <= s_axis_tdata[31:0];
			vy_q <= s_axis_tdata[63:32];
		end else if (state_q == ST_LOAD) begin
			x_q  <= ram_rdata[VW-1:0];
			vx_q <= ram_rdata[2*VW-1:VW];
			y_q  <= ram_rdata[3*VW-1:2*VW];
			vy_q <= ram_rdata[4*VW-1:3*VW];
		end else if (state_q == ST_MUL && ph_q == PH_USE) begin
			case (step_q)
				STP_LX: vx_q <= mul_p;
				STP_LY: vy_q <= mul_p;
				STP_GX: x_q <= add_x_c;
				STP_DX: t_q <= mul_p;
				STP_TX: vx_q <= sub_vx_c;
				STP_GY: y_q <= add_y_c;
				STP_DY: t_q <= mul_p;
				STP_TY: acc_q <= acc_c;
				STP_GR: vy_q <= vy_grav_c;
				STP_RS: begin
					vy_q <= vy_bounce_c;
					y_q  <= '0;
				end
				default: ;
			endcase
		end

		// load the output word
		if (out_load_c) begin
			out_kind_q <= tick_q ? bpi_pkg::KIND_POS : bpi_pkg::KIND_ACK;
			out_full_q <= full_q;
			out_last_q <= tick_q ? last_ball_c : 1'b1;
			out_idx_q  <= XW'(idx_q);
			out_x_q    <= x_q;
			out_y_q    <= y_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_y_q, out_x_q, out_idx_q};
	assign m_axis_tuser  = {out_full_q, out_kind_q};
	assign m_axis_tlast  = out_last_q;

	`BPI_ASSERT_NEXT(a_tick_empty,
		in_acc_c && op_c == bpi_pkg::OP_TICK && count_q == '0,
		state_q == ST_IDLE, "tick with no balls did not return to idle")
	`BPI_ASSERT_NEXT(a_press_pauses, in_acc_c && op_c == bpi_pkg::OP_PRESS,
		!running_q, "press did not pause motion")
	`BPI_ASSERT_SAME(a_pos_idx, out_load_c && tick_q, CW'(idx_q) < count_q,
		"reported ball index beyond ball count")
	`BPI_ASSERT_NEXT(a_spawn_count, state_q == ST_WR && !tick_q,
		count_q == $past(count_q) + CW'(1), "spawn did not add one ball")
	`BPI_ASSERT_SAME(a_height_floor, state_q == ST_WR && tick_q, !y_q[VW-1],
		"stored height below ground")

endmodule

`default_nettype wire
